FILE: hdl/bmrsc_pkg.sv
// Shared types, constants and the byte population count for the range bitmap block.
package bmrsc_pkg;

  localparam int OP_W    = 2;
  localparam int RANGE_W = 13;
  localparam int CNT_W   = 13;

  typedef enum logic [OP_W-1:0] {
    OP_SET       = 2'd0,
    OP_CLEAR     = 2'd1,
    OP_COUNT     = 2'd2,
    OP_CLEAR_ALL = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_TAIL,
    S_DONE
  } state_e;

  // Ones in one byte; a constant 256-entry table once synthesized.
  function automatic logic [3:0] byte_ones(input logic [7:0] b);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      n = n + 4'(b[i]);
    end
    return n;
  endfunction

endpackage

FILE: hdl/bmrsc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bmrsc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic                                        re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/bitmap_range_set_clear_count.sv
// Top level: range bitmap with set, clear, count and clear-all operations.
//
// Input channel (in_valid_i / in_stall_o): one item is an op and a half-open
// bit range [range_start_i, range_end_i). Both ends are clipped to MAP_BITS.
// Output channel (out_valid_o / out_stall_i): exactly one item per input item,
// carrying set_count_o and range_empty_o (both zero unless the op is count).
//
// Timing: a set, clear or count with a non-empty range walks every word of
// the map through one read-modify-write pipe, one word per cycle, then passes
// the tail state and loads the output register in the done state. Clear-all and
// empty ranges skip the walk and go straight to the done state. The word RAM's
// single read and single write port set the walk rate. A new item is taken only
// while the sequencer is idle, i.e. one item at a time.
//
// Reset: per-word valid bits are cleared, so the whole map reads as zero at
// once; clear-all does the same. No clearing sweep is needed.
// Stall: the result sits in an output register; a new item may be accepted
// while it waits, and the sequencer holds its next result until it drains.
module bitmap_range_set_clear_count #(
  parameter int MAP_BITS  = 4096,
  parameter int WORD_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [bmrsc_pkg::OP_W-1:0]    op_i,
  input  logic [bmrsc_pkg::RANGE_W-1:0] range_start_i,
  input  logic [bmrsc_pkg::RANGE_W-1:0] range_end_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [bmrsc_pkg::CNT_W-1:0]   set_count_o,
  output logic                          range_empty_o
);

  import bmrsc_pkg::*;

  localparam int MAP_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int IDX_W     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int SPAN      = MAP_WORDS * WORD_BITS;
  localparam int BASE_W    = $clog2(SPAN + WORD_BITS + 1);
  localparam int CMP_W     = (BASE_W > RANGE_W) ? BASE_W : RANGE_W;
  localparam int SH_W      = $clog2(WORD_BITS);
  localparam int NBYTES    = (WORD_BITS + 7) / 8;
  localparam int PAD_W     = NBYTES * 8;
  localparam int SUM_W     = $clog2(WORD_BITS + 1);

  localparam logic [WORD_BITS-1:0] ALL_ONES = {WORD_BITS{1'b1}};
  localparam logic [CMP_W-1:0]     MAP_TOP  = CMP_W'(MAP_BITS);
  localparam logic [CMP_W-1:0]     W_STEP   = CMP_W'(WORD_BITS);
  localparam logic [IDX_W-1:0]     LAST_IDX = IDX_W'(MAP_WORDS - 1);

  // sequencer and control
  state_e state_q, state_d;
  op_e    op_q, op_d;
  logic [MAP_WORDS-1:0] vld_q, vld_d;
  logic   p_vld_q, p_vld_d;
  logic   out_vld_q, out_vld_d;

  // walk payload
  logic [CMP_W-1:0]     lo_q, lo_d, hi_q, hi_d;
  logic [CMP_W-1:0]     base_q, base_d;
  logic [IDX_W-1:0]     rd_idx_q, rd_idx_d;
  logic [IDX_W-1:0]     p_idx_q, p_idx_d;
  logic [WORD_BITS-1:0] p_mask_q, p_mask_d;
  logic                 p_hit_q, p_hit_d;
  logic [CNT_W-1:0]     acc_q, acc_d;
  logic [CNT_W-1:0]     out_cnt_q, out_cnt_d;
  logic                 out_emp_q, out_emp_d;

  // datapath wires
  logic [CMP_W-1:0]     s_ext, e_ext, s_clip, e_clip;
  logic [CMP_W-1:0]     base_top, lo_off, hi_off;
  logic [WORD_BITS-1:0] lo_m, hi_m;
  logic [WORD_BITS-1:0] ram_rdata, word, masked, ram_wdata;
  logic [PAD_W-1:0]     padded;
  logic [SUM_W-1:0]     pop;
  logic                 ram_we, ram_re, in_acc;

  assign in_acc     = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);

  // clip both ends to the map
  assign s_ext  = CMP_W'(range_start_i);
  assign e_ext  = CMP_W'(range_end_i);
  assign s_clip = (s_ext > MAP_TOP) ? MAP_TOP : s_ext;
  assign e_clip = (e_ext > MAP_TOP) ? MAP_TOP : e_ext;

  // stage 1: mask of the word at base_q
  assign base_top = base_q + W_STEP;
  assign lo_off   = lo_q - base_q;
  assign hi_off   = hi_q - base_q;

  always_comb begin
    if (lo_q <= base_q) begin
      lo_m = ALL_ONES;
    end else if (lo_q >= base_top) begin
      lo_m = '0;
    end else begin
      lo_m = ALL_ONES << lo_off[SH_W-1:0];
    end
    if (hi_q >= base_top) begin
      hi_m = ALL_ONES;
    end else if (hi_q <= base_q) begin
      hi_m = '0;
    end else begin
      hi_m = ~(ALL_ONES << hi_off[SH_W-1:0]);
    end
  end

  // stage 2: word from RAM, never-written words read as zero
  assign word   = p_hit_q ? ram_rdata : '0;
  assign masked = word & p_mask_q;
  assign padded = PAD_W'(masked);

  always_comb begin
    pop = '0;
    for (int i = 0; i < NBYTES; i++) begin
      pop = pop + SUM_W'(byte_ones(padded[i*8 +: 8]));
    end
  end

  assign ram_we    = p_vld_q && ((op_q == OP_SET) || (op_q == OP_CLEAR));
  assign ram_wdata = (op_q == OP_SET) ? (word | p_mask_q) : (word & ~p_mask_q);
  assign ram_re    = (state_q == S_WALK);

  bmrsc_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(MAP_WORDS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(p_idx_q),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(rd_idx_q),
    .rdata_o(ram_rdata)
  );

  // sequencer: next state and datapath controls
  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    vld_d     = vld_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    base_d    = base_q;
    rd_idx_d  = rd_idx_q;
    p_vld_d   = 1'b0;
    p_idx_d   = rd_idx_q;
    p_mask_d  = lo_m & hi_m;
    p_hit_d   = vld_q[rd_idx_q];
    acc_d     = acc_q;
    out_vld_d = out_vld_q;
    out_cnt_d = out_cnt_q;
    out_emp_d = out_emp_q;

    if (out_vld_q && !out_stall_i) begin
      out_vld_d = 1'b0;
    end

    // count accumulates whatever word leaves stage 2
    if (p_vld_q) begin
      acc_d = acc_q + CNT_W'(pop);
    end
    if (ram_we) begin
      vld_d[p_idx_q] = 1'b1;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          op_d     = op_e'(op_i);
          lo_d     = s_clip;
          hi_d     = e_clip;
          base_d   = '0;
          rd_idx_d = '0;
          acc_d    = '0;
          if (op_e'(op_i) == OP_CLEAR_ALL) begin
            vld_d   = '0;
            state_d = S_DONE;
          end else if (s_clip >= e_clip) begin
            state_d = S_DONE;
          end else begin
            state_d = S_WALK;
          end
        end
      end
      S_WALK: begin
        p_vld_d  = 1'b1;
        base_d   = base_top;
        rd_idx_d = rd_idx_q + 1'b1;
        if (rd_idx_q == LAST_IDX) begin
          state_d = S_TAIL;
        end
      end
      S_TAIL: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_vld_q || !out_stall_i) begin
          out_vld_d = 1'b1;
          out_cnt_d = (op_q == OP_COUNT) ? acc_q : '0;
          out_emp_d = (op_q == OP_COUNT) && (acc_q == '0);
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      op_q      <= OP_SET;
      vld_q     <= '0;
      p_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      op_q      <= op_d;
      vld_q     <= vld_d;
      p_vld_q   <= p_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    base_q    <= base_d;
    rd_idx_q  <= rd_idx_d;
    p_idx_q   <= p_idx_d;
    p_mask_q  <= p_mask_d;
    p_hit_q   <= p_hit_d;
    acc_q     <= acc_d;
    out_cnt_q <= out_cnt_d;
    out_emp_q <= out_emp_d;
  end

  assign out_valid_o   = out_vld_q;
  assign set_count_o   = out_cnt_q;
  assign range_empty_o = out_emp_q;

endmodule

FILE: hdl/bmrsc_chk.sv
// Port-level checker for the range bitmap block, bound to its top level.
module bmrsc_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic [bmrsc_pkg::OP_W-1:0]    op_i,
  input logic [bmrsc_pkg::RANGE_W-1:0] range_start_i,
  input logic [bmrsc_pkg::RANGE_W-1:0] range_end_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [bmrsc_pkg::CNT_W-1:0]   set_count_o,
  input logic                          range_empty_o
);

  import bmrsc_pkg::*;

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(set_count_o)
      && $stable(range_empty_o))
    else $error("result changed while stalled");

  // one item at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again before item finished");

  // empty flag and a nonzero count exclude each other
  a_empty_vs_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(range_empty_o && (set_count_o != '0)))
    else $error("range_empty with nonzero count");

  // a new result only appears out of a busy sequencer
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared with no item in work");

endmodule

bind bitmap_range_set_clear_count bmrsc_chk u_bmrsc_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .op_i         (op_i),
  .range_start_i(range_start_i),
  .range_end_i  (range_end_i),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .set_count_o  (set_count_o),
  .range_empty_o(range_empty_o)
);
